[hdl/cddc_pkg.sv]
// Shared constants, types and calendar helper functions for the civil date converter.
package cddc_pkg;

    localparam int YEAR_BITS_DEF = 16;
    localparam int DAYCOUNT_BITS = 25;
    localparam int PIPE_DEPTH    = 8;
    localparam int ERA_DAYS      = 146097;
    localparam int EPOCH_SHIFT   = 719468;

    typedef logic [PIPE_DEPTH-1:0] t_pipe_en;

    // first day of a March-based month, counted from March 1
    function automatic logic [8:0] mar_month_start(input logic [3:0] mp);
        logic [8:0] start;
        unique case (mp)
            4'd0:  start = 9'd0;
            4'd1:  start = 9'd31;
            4'd2:  start = 9'd61;
            4'd3:  start = 9'd92;
            4'd4:  start = 9'd122;
            4'd5:  start = 9'd153;
            4'd6:  start = 9'd184;
            4'd7:  start = 9'd214;
            4'd8:  start = 9'd245;
            4'd9:  start = 9'd275;
            4'd10: start = 9'd306;
            4'd11: start = 9'd337;
            4'd12: start = 9'd367;
            4'd13: start = 9'd398;
            4'd14: start = 9'd428;
            4'd15: start = 9'd459;
        endcase
        return start;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // leap flag from the year modulo 400 (a value of 400 acts as 0)
    function automatic logic leap_of(input logic [8:0] ymod);
        return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

    function automatic logic [1:0] div100(input logic [8:0] v);
        logic [1:0] q;
        priority if (v >= 9'd300) begin
            q = 2'd3;
        end else if (v >= 9'd200) begin
            q = 2'd2;
        end else if (v >= 9'd100) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return q;
    endfunction

endpackage

[hdl/cddc_to_days.sv]
// Pipelined date to day count conversion with leap, month length and validity flags.
module cddc_to_days #(
    parameter int YEAR_BITS = cddc_pkg::YEAR_BITS_DEF
) (
    input  logic                                    i_clk,
    input  cddc_pkg::t_pipe_en                      i_en,
    input  logic signed [YEAR_BITS-1:0]             i_year,
    input  logic [3:0]                              i_month,
    input  logic [4:0]                              i_day,
    output logic [cddc_pkg::DAYCOUNT_BITS-1:0]      o_day_count,
    output logic                                    o_leap,
    output logic [4:0]                              o_month_length,
    output logic                                    o_date_valid
);

    localparam int DCB = cddc_pkg::DAYCOUNT_BITS;
    localparam int DLY = cddc_pkg::PIPE_DEPTH - 4;
    localparam longint unsigned BIAS    = 64'd25 << (YEAR_BITS - 5);
    localparam longint unsigned ERA_OFS = 64'd1 << (YEAR_BITS - 5);
    localparam longint unsigned RECIP   = (64'd1 << YEAR_BITS) / 64'd25;

    typedef struct packed {
        logic [DCB-1:0] days;
        logic           leap;
        logic [4:0]     mlen;
        logic           valid;
    } t_days_res;

    // stage 1: March-based month, day of year, biased year / 16
    logic                        adj1;
    logic signed [YEAR_BITS:0]   y1;
    logic signed [YEAR_BITS:0]   sh1;
    logic signed [YEAR_BITS:0]   vb1;
    logic [3:0]                  mp1;
    logic [YEAR_BITS-1:0]        n_v1;
    logic signed [9:0]           n_doy1;
    logic [YEAR_BITS-1:0]        r_v1;
    logic [3:0]                  r_ylo1;
    logic signed [9:0]           r_doy1;
    logic                        r_adj1;
    logic [3:0]                  r_month1;
    logic [4:0]                  r_day1;

    always_comb begin
        adj1   = (i_month <= 4'd2);
        y1     = (YEAR_BITS+1)'(i_year) - (YEAR_BITS+1)'(adj1);
        sh1    = y1 >>> 4;
        vb1    = sh1 + $signed((YEAR_BITS+1)'(BIAS));
        n_v1   = vb1[YEAR_BITS-1:0];
        mp1    = (i_month > 4'd2) ? i_month - 4'd3 : i_month + 4'd9;
        n_doy1 = $signed({1'b0, cddc_pkg::mar_month_start(mp1)})
               + $signed({5'd0, i_day}) - 10'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_v1     <= n_v1;
            r_ylo1   <= y1[3:0];
            r_doy1   <= n_doy1;
            r_adj1   <= adj1;
            r_month1 <= i_month;
            r_day1   <= i_day;
        end
    end

    // stage 2: reciprocal estimate of (y / 16) / 25
    logic [2*YEAR_BITS-1:0] prod2;
    logic [YEAR_BITS-1:0]   r_q2;
    logic [YEAR_BITS-1:0]   r_v2;
    logic [3:0]             r_ylo2;
    logic signed [9:0]      r_doy2;
    logic                   r_adj2;
    logic [3:0]             r_month2;
    logic [4:0]             r_day2;

    assign prod2 = (2*YEAR_BITS)'(r_v1) * (2*YEAR_BITS)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_q2     <= prod2[2*YEAR_BITS-1:YEAR_BITS];
            r_v2     <= r_v1;
            r_ylo2   <= r_ylo1;
            r_doy2   <= r_doy1;
            r_adj2   <= r_adj1;
            r_month2 <= r_month1;
            r_day2   <= r_day1;
        end
    end

    // stage 3: quotient correction, era and year of era
    logic [YEAR_BITS-1:0]      rem3;
    logic                      fix3;
    logic [YEAR_BITS-1:0]      q3;
    logic [4:0]                rr3;
    logic signed [YEAR_BITS:0] era3;
    logic [DCB-1:0]            r_era3;
    logic [8:0]                r_yoe3;
    logic signed [9:0]         r_doy3;
    logic                      r_adj3;
    logic [3:0]                r_month3;
    logic [4:0]                r_day3;

    always_comb begin
        rem3 = r_v2 - YEAR_BITS'(r_q2 * YEAR_BITS'(25));
        fix3 = (rem3 >= YEAR_BITS'(25));
        q3   = r_q2 + YEAR_BITS'(fix3);
        rr3  = fix3 ? 5'(rem3 - YEAR_BITS'(25)) : rem3[4:0];
        era3 = $signed({1'b0, q3}) - $signed((YEAR_BITS+1)'(ERA_OFS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_era3   <= DCB'(era3);
            r_yoe3   <= {rr3, r_ylo2};
            r_doy3   <= r_doy2;
            r_adj3   <= r_adj2;
            r_month3 <= r_month2;
            r_day3   <= r_day2;
        end
    end

    // stage 4: day of era, leap flag, month length, validity
    logic [18:0]    doe4;
    logic           leap4;
    logic [4:0]     mlen4;
    logic           valid4;
    logic [DCB-1:0] r_era4;
    logic [18:0]    r_doe4;
    logic           r_leap4;
    logic [4:0]     r_mlen4;
    logic           r_valid4;

    always_comb begin
        doe4   = 19'(r_yoe3) * 19'd365 + 19'(r_yoe3[8:2])
               - 19'(cddc_pkg::div100(r_yoe3)) + 19'(r_doy3);
        leap4  = cddc_pkg::leap_of(r_yoe3 + 9'(r_adj3));
        mlen4  = cddc_pkg::month_len(r_month3, leap4);
        valid4 = (mlen4 != 5'd0) && (r_day3 != 5'd0) && (r_day3 <= mlen4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_era4   <= r_era3;
            r_doe4   <= doe4;
            r_leap4  <= leap4;
            r_mlen4  <= mlen4;
            r_valid4 <= valid4;
        end
    end

    // stage 5: day count modulo the field width, then delay to the common depth
    t_days_res n_res5;
    t_days_res r_res [DLY];

    always_comb begin
        n_res5.days  = r_era4 * DCB'(cddc_pkg::ERA_DAYS) + DCB'($signed(r_doe4))
                     - DCB'(cddc_pkg::EPOCH_SHIFT);
        n_res5.leap  = r_leap4;
        n_res5.mlen  = r_mlen4;
        n_res5.valid = r_valid4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_res[0] <= n_res5;
        end
        for (int k = 1; k < DLY; k++) begin
            if (i_en[k+4]) begin
                r_res[k] <= r_res[k-1];
            end
        end
    end

    assign o_day_count    = r_res[DLY-1].days;
    assign o_leap         = r_res[DLY-1].leap;
    assign o_month_length = r_res[DLY-1].mlen;
    assign o_date_valid   = r_res[DLY-1].valid;

endmodule

[hdl/cddc_to_date.sv]
// Pipelined day count to date conversion with leap, month length and year saturation.
module cddc_to_date #(
    parameter int YEAR_BITS = cddc_pkg::YEAR_BITS_DEF
) (
    input  logic                                      i_clk,
    input  cddc_pkg::t_pipe_en                        i_en,
    input  logic signed [cddc_pkg::DAYCOUNT_BITS-1:0] i_day_count,
    output logic signed [YEAR_BITS-1:0]               o_year,
    output logic [3:0]                                o_month,
    output logic [4:0]                                o_day,
    output logic                                      o_leap,
    output logic [4:0]                                o_month_length,
    output logic                                      o_out_of_range
);

    localparam int ZB_BITS     = 26;
    localparam int ERA_BIAS    = 115;
    localparam int ZB_OFS      = cddc_pkg::EPOCH_SHIFT + ERA_BIAS * cddc_pkg::ERA_DAYS;
    localparam int ERA_RECIP   = (1 << ZB_BITS) / cddc_pkg::ERA_DAYS;
    localparam int RECIP_1460  = ((1 << 28) + 1459) / 1460;
    localparam int RECIP_365   = ((1 << 26) + 364) / 365;
    localparam int RECIP_153   = ((1 << 20) + 152) / 153;
    localparam int CENT_DAYS   = 36524;
    localparam longint YMAX    = (64'sd1 <<< (YEAR_BITS - 1)) - 64'sd1;
    localparam longint YMIN    = -YMAX - 64'sd1;

    // stage 1: biased day count from March 1 of year 0
    logic [ZB_BITS-1:0] r_zb1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_zb1 <= ZB_BITS'(i_day_count) + ZB_BITS'(ZB_OFS);
        end
    end

    // stage 2: era estimate
    logic [ZB_BITS+8:0] prod2;
    logic [7:0]         r_q2;
    logic [ZB_BITS-1:0] r_zb2;

    assign prod2 = (ZB_BITS+9)'(r_zb1) * (ZB_BITS+9)'(ERA_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_q2  <= prod2[ZB_BITS+7:ZB_BITS];
            r_zb2 <= r_zb1;
        end
    end

    // stage 3: era correction, day of era
    logic [ZB_BITS-1:0] rem3;
    logic               fix3;
    logic [8:0]         q3;
    logic signed [8:0]  r_era3;
    logic [17:0]        r_doe3;

    always_comb begin
        rem3 = r_zb2 - ZB_BITS'(r_q2) * ZB_BITS'(cddc_pkg::ERA_DAYS);
        fix3 = (rem3 >= ZB_BITS'(cddc_pkg::ERA_DAYS));
        q3   = 9'(r_q2) + 9'(fix3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_era3 <= $signed(q3) - 9'sd115;
            r_doe3 <= fix3 ? 18'(rem3 - ZB_BITS'(cddc_pkg::ERA_DAYS)) : rem3[17:0];
        end
    end

    // stage 4: leap-day corrections of the day of era
    logic [35:0]       prod4;
    logic [2:0]        cent4;
    logic [6:0]        r_q4;
    logic [2:0]        r_cent4;
    logic              r_last4;
    logic [17:0]       r_doe4;
    logic signed [8:0] r_era4;

    always_comb begin
        prod4 = 36'(r_doe3) * 36'(RECIP_1460);
        cent4 = 3'(r_doe3 >= 18'(CENT_DAYS)) + 3'(r_doe3 >= 18'(2 * CENT_DAYS))
              + 3'(r_doe3 >= 18'(3 * CENT_DAYS)) + 3'(r_doe3 >= 18'(4 * CENT_DAYS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_q4    <= prod4[34:28];
            r_cent4 <= cent4;
            r_last4 <= (r_doe3 == 18'(cddc_pkg::ERA_DAYS - 1));
            r_doe4  <= r_doe3;
            r_era4  <= r_era3;
        end
    end

    // stage 5: day of era on a 365-day grid
    logic [17:0]       r_x5;
    logic [17:0]       r_doe5;
    logic signed [8:0] r_era5;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_x5   <= r_doe4 - 18'(r_q4) + 18'(r_cent4) - 18'(r_last4);
            r_doe5 <= r_doe4;
            r_era5 <= r_era4;
        end
    end

    // stage 6: year of era
    logic [35:0]       prod6;
    logic [8:0]        r_yoe6;
    logic [17:0]       r_doe6;
    logic signed [8:0] r_era6;

    assign prod6 = 36'(r_x5) * 36'(RECIP_365);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_yoe6 <= prod6[34:26];
            r_doe6 <= r_doe5;
            r_era6 <= r_era5;
        end
    end

    // stage 7: day of March-based year
    logic [17:0]       ystart7;
    logic [8:0]        r_doy7;
    logic [8:0]        r_yoe7;
    logic signed [8:0] r_era7;

    assign ystart7 = 18'(r_yoe6) * 18'd365 + 18'(r_yoe6[8:2])
                   - 18'(cddc_pkg::div100(r_yoe6));

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_doy7 <= 9'(r_doe6 - ystart7);
            r_yoe7 <= r_yoe6;
            r_era7 <= r_era6;
        end
    end

    // stage 8: March-based month
    logic [10:0]       num8;
    logic [23:0]       prod8;
    logic [3:0]        r_mp8;
    logic [8:0]        r_doy8;
    logic [8:0]        r_yoe8;
    logic signed [8:0] r_era8;

    always_comb begin
        num8  = 11'(r_doy7) * 11'd5 + 11'd2;
        prod8 = 24'(num8) * 24'(RECIP_153);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_mp8  <= prod8[23:20];
            r_doy8 <= r_doy7;
            r_yoe8 <= r_yoe7;
            r_era8 <= r_era7;
        end
    end

    // final: civil month, day, year and flags
    logic               adj9;
    logic [3:0]         month9;
    logic signed [17:0] year9;
    logic signed [63:0] y64;
    logic               hi9;
    logic               lo9;
    logic signed [63:0] ysat9;

    always_comb begin
        month9 = (r_mp8 < 4'd10) ? r_mp8 + 4'd3 : r_mp8 - 4'd9;
        adj9   = (month9 <= 4'd2);
        year9  = 18'(r_era8) * 18'sd400 + $signed({9'd0, r_yoe8}) + $signed({17'd0, adj9});
        y64    = 64'(year9);
        hi9    = (y64 > YMAX);
        lo9    = (y64 < YMIN);
        ysat9  = hi9 ? YMAX : (lo9 ? YMIN : y64);
    end

    assign o_year         = YEAR_BITS'(ysat9);
    assign o_month        = month9;
    assign o_day          = 5'(r_doy8 - cddc_pkg::mar_month_start(r_mp8) + 9'd1);
    assign o_leap         = cddc_pkg::leap_of(r_yoe8 + 9'(adj9));
    assign o_month_length = cddc_pkg::month_len(month9, o_leap);
    assign o_out_of_range = hi9 || lo9;

endmodule

[hdl/civil_date_day_count_converter_unit.sv]
// Top level of the civil date / day count converter: request pipeline and output register.
// Requests pass eight stages of constant-reciprocal multiplies, then the output register.
// Throughput: one request per cycle while the output is not stalled.
// A stall holds only full stages; empty stages ahead of it keep taking requests.
// Reset (synchronous, active low) clears the stage and output valid bits only.
module civil_date_day_count_converter_unit #(
    parameter int YEAR_BITS = cddc_pkg::YEAR_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic                                      i_func,
    input  logic signed [YEAR_BITS-1:0]               i_year_in,
    input  logic [3:0]                                i_month_in,
    input  logic [4:0]                                i_day_in,
    input  logic signed [cddc_pkg::DAYCOUNT_BITS-1:0] i_day_count_in,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [cddc_pkg::DAYCOUNT_BITS-1:0] o_day_count_out,
    output logic signed [YEAR_BITS-1:0]               o_year_out,
    output logic [3:0]                                o_month_out,
    output logic [4:0]                                o_day_out,
    output logic                                      o_leap_year,
    output logic [4:0]                                o_month_length,
    output logic                                      o_date_valid,
    output logic                                      o_out_of_range
);

    localparam int   DEPTH        = cddc_pkg::PIPE_DEPTH;
    localparam int   DCB          = cddc_pkg::DAYCOUNT_BITS;
    localparam logic FUNC_TO_DATE = 1'b1;

    cddc_pkg::t_pipe_en en;
    logic               en_out;
    logic [DEPTH-1:0]   r_vld;
    logic [DEPTH-1:0]   r_func;
    logic               r_out_vld;

    always_comb begin
        en_out       = !r_out_vld || !i_out_stall;
        en[DEPTH-1]  = !r_vld[DEPTH-1] || en_out;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < DEPTH; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en_out) begin
                r_out_vld <= r_vld[DEPTH-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_func[0] <= i_func;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (en[k]) begin
                r_func[k] <= r_func[k-1];
            end
        end
    end

    logic [DCB-1:0]             td_day_count;
    logic                       td_leap;
    logic [4:0]                 td_mlen;
    logic                       td_valid;
    logic signed [YEAR_BITS-1:0] tc_year;
    logic [3:0]                 tc_month;
    logic [4:0]                 tc_day;
    logic                       tc_leap;
    logic [4:0]                 tc_mlen;
    logic                       tc_oor;

    cddc_to_days #(
        .YEAR_BITS(YEAR_BITS)
    ) u_to_days (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_year         (i_year_in),
        .i_month        (i_month_in),
        .i_day          (i_day_in),
        .o_day_count    (td_day_count),
        .o_leap         (td_leap),
        .o_month_length (td_mlen),
        .o_date_valid   (td_valid)
    );

    cddc_to_date #(
        .YEAR_BITS(YEAR_BITS)
    ) u_to_date (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_day_count    (i_day_count_in),
        .o_year         (tc_year),
        .o_month        (tc_month),
        .o_day          (tc_day),
        .o_leap         (tc_leap),
        .o_month_length (tc_mlen),
        .o_out_of_range (tc_oor)
    );

    logic [DCB-1:0]              r_dc_out;
    logic signed [YEAR_BITS-1:0] r_year_out;
    logic [3:0]                  r_month_out;
    logic [4:0]                  r_day_out;
    logic                        r_leap_out;
    logic [4:0]                  r_mlen_out;
    logic                        r_valid_out;
    logic                        r_oor_out;

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            if (r_func[DEPTH-1] == FUNC_TO_DATE) begin
                r_dc_out    <= '0;
                r_year_out  <= tc_year;
                r_month_out <= tc_month;
                r_day_out   <= tc_day;
                r_leap_out  <= tc_leap;
                r_mlen_out  <= tc_mlen;
                r_valid_out <= 1'b1;
                r_oor_out   <= tc_oor;
            end else begin
                r_dc_out    <= td_day_count;
                r_year_out  <= '0;
                r_month_out <= 4'd0;
                r_day_out   <= 5'd0;
                r_leap_out  <= td_leap;
                r_mlen_out  <= td_mlen;
                r_valid_out <= td_valid;
                r_oor_out   <= 1'b0;
            end
        end
    end

    assign o_day_count_out = $signed(r_dc_out);
    assign o_year_out      = r_year_out;
    assign o_month_out     = r_month_out;
    assign o_day_out       = r_day_out;
    assign o_leap_year     = r_leap_out;
    assign o_month_length  = r_mlen_out;
    assign o_date_valid    = r_valid_out;
    assign o_out_of_range  = r_oor_out;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_vld) && r_out_vld && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_oor_only_to_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_oor_out) |-> ((r_dc_out == '0) && r_valid_out))
        else $error("out-of-range flag on a date to day count result");

    a_calendar_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_month_out != 4'd0)) |->
        ((r_month_out <= 4'd12) && (r_day_out != 5'd0) && (r_day_out <= r_mlen_out)))
        else $error("converted date outside its month");

    a_february_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_month_out == 4'd2)) |->
        (r_mlen_out == (r_leap_out ? 5'd29 : 5'd28)))
        else $error("February length disagrees with leap flag");

endmodule

[dv/cddc_tb_pkg.sv]
// Conversion direction codes shared by the converter testbench and its checker.
`timescale 1ns / 100ps
package cddc_tb_pkg;

    localparam logic FUNC_DATE_TO_DAYS = 1'b0;
    localparam logic FUNC_DAYS_TO_DATE = 1'b1;

endpackage

[dv/cddc_checker.sv]
// Checker for the civil date converter: predicts each accepted request and compares results.
`timescale 1ns / 100ps
module cddc_checker #(
    parameter int YEAR_BITS = cddc_pkg::YEAR_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_stall,
    input  logic                                      i_func,
    input  logic signed [YEAR_BITS-1:0]               i_year_in,
    input  logic [3:0]                                i_month_in,
    input  logic [4:0]                                i_day_in,
    input  logic signed [cddc_pkg::DAYCOUNT_BITS-1:0] i_day_count_in,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_stall,
    input  logic signed [cddc_pkg::DAYCOUNT_BITS-1:0] i_day_count_out,
    input  logic signed [YEAR_BITS-1:0]               i_year_out,
    input  logic [3:0]                                i_month_out,
    input  logic [4:0]                                i_day_out,
    input  logic                                      i_leap_year,
    input  logic [4:0]                                i_month_length,
    input  logic                                      i_date_valid,
    input  logic                                      i_out_of_range,
    output int                                        o_mismatches,
    output int                                        o_pending
);

    localparam int DCB = cddc_pkg::DAYCOUNT_BITS;

    typedef struct {
        logic signed [DCB-1:0]           day_count;
        logic signed [YEAR_BITS-1:0]     year;
        logic [3:0]                      month;
        logic [4:0]                      day;
        logic                            leap;
        logic [4:0]                      month_length;
        logic                            date_valid;
        logic                            out_of_range;
    } t_conversion;

    t_conversion conversions_due[$];
    t_conversion oldest;
    int          mismatch_count = 0;

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic gregorian_leap(longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [4:0] days_in_month(longint y, longint m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 5'd31;
            4, 6, 9, 11:           return 5'd30;
            2:                     return gregorian_leap(y) ? 5'd29 : 5'd28;
            default:               return 5'd0;
        endcase
    endfunction

    function automatic t_conversion convert_request(
        logic                            func,
        logic signed [YEAR_BITS-1:0]     year_in,
        logic [3:0]                      month_in,
        logic [4:0]                      day_in,
        logic signed [DCB-1:0]           count_in
    );
        t_conversion r;
        longint      yr, mo, dy, y, era, yoe, doe, doy, mp, days, z, ymax, ymin;
        r.day_count    = '0;
        r.year         = '0;
        r.month        = '0;
        r.day          = '0;
        r.leap         = 1'b0;
        r.month_length = '0;
        r.date_valid   = 1'b0;
        r.out_of_range = 1'b0;
        if (func == cddc_tb_pkg::FUNC_DATE_TO_DAYS) begin
            yr   = longint'(year_in);
            mo   = longint'(month_in);
            dy   = longint'(day_in);
            y    = yr - ((mo <= 2) ? 1 : 0);
            era  = floor_quot(y, 400);
            yoe  = y - era * 400;
            mp   = (mo > 2) ? mo - 3 : mo + 9;
            doy  = (153 * mp + 2) / 5 + dy - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * cddc_pkg::ERA_DAYS + doe - cddc_pkg::EPOCH_SHIFT;
            r.day_count    = days[DCB-1:0];
            r.leap         = gregorian_leap(yr);
            r.month_length = days_in_month(yr, mo);
            r.date_valid   = (r.month_length != 0) && (dy >= 1) && (dy <= r.month_length);
        end else begin
            z    = longint'(count_in) + cddc_pkg::EPOCH_SHIFT;
            era  = floor_quot(z, cddc_pkg::ERA_DAYS);
            doe  = z - era * cddc_pkg::ERA_DAYS;
            yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp   = (5 * doy + 2) / 153;
            dy   = doy - (153 * mp + 2) / 5 + 1;
            mo   = (mp < 10) ? mp + 3 : mp - 9;
            y    = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
            ymax = (longint'(1) << (YEAR_BITS - 1)) - 1;
            ymin = -ymax - 1;
            if (y > ymax) begin
                r.year         = ymax[YEAR_BITS-1:0];
                r.out_of_range = 1'b1;
            end else if (y < ymin) begin
                r.year         = ymin[YEAR_BITS-1:0];
                r.out_of_range = 1'b1;
            end else begin
                r.year = y[YEAR_BITS-1:0];
            end
            r.month        = mo[3:0];
            r.day          = dy[4:0];
            r.leap         = gregorian_leap(y);
            r.month_length = days_in_month(y, mo);
            r.date_valid   = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (conversions_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none, got day_count %0d year %0d",
                             $time, i_day_count_out, i_year_out);
                end else begin
                    oldest = conversions_due.pop_front();
                    check_field("day_count_out", oldest.day_count, i_day_count_out);
                    check_field("year_out", oldest.year, i_year_out);
                    check_field("month_out", oldest.month, i_month_out);
                    check_field("day_out", oldest.day, i_day_out);
                    check_field("leap_year", oldest.leap, i_leap_year);
                    check_field("month_length", oldest.month_length, i_month_length);
                    check_field("date_valid", oldest.date_valid, i_date_valid);
                    check_field("out_of_range", oldest.out_of_range, i_out_of_range);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                conversions_due.push_back(convert_request(i_func, i_year_in, i_month_in,
                                                          i_day_in, i_day_count_in));
            end
        end
        o_pending <= conversions_due.size();
    end

    assign o_mismatches = mismatch_count;

endmodule

[dv/tb_top.sv]
// Testbench top for the civil date converter: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam int YEAR_W          = cddc_pkg::YEAR_BITS_DEF;
    localparam int COUNT_W         = cddc_pkg::DAYCOUNT_BITS;
    localparam int RANDOM_REQUESTS = 400;
    localparam int IDLE_PERCENT    = 38;
    localparam int TIMEOUT_NS      = 2_000_000;
    // day counts of 32767-12-31 and -32768-01-01, the edges of the year field
    localparam int TOP_YEAR_LAST_DAY     = 11248737;
    localparam int BOTTOM_YEAR_FIRST_DAY = -12687794;

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_stall;
    logic                            req_func;
    logic signed [YEAR_W-1:0]        req_year;
    logic [3:0]                      req_month;
    logic [4:0]                      req_day;
    logic signed [COUNT_W-1:0]       req_count;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    logic signed [COUNT_W-1:0]       res_count;
    logic signed [YEAR_W-1:0]        res_year;
    logic [3:0]                      res_month;
    logic [4:0]                      res_day;
    logic                            res_leap;
    logic [4:0]                      res_month_length;
    logic                            res_date_valid;
    logic                            res_out_of_range;
    logic                            no_idle;
    int                              mismatches;
    int                              pending;

    civil_date_day_count_converter_unit #(
        .YEAR_BITS(YEAR_W)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_stall     (req_stall),
        .i_func         (req_func),
        .i_year_in      (req_year),
        .i_month_in     (req_month),
        .i_day_in       (req_day),
        .i_day_count_in (req_count),
        .o_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .o_day_count_out(res_count),
        .o_year_out     (res_year),
        .o_month_out    (res_month),
        .o_day_out      (res_day),
        .o_leap_year    (res_leap),
        .o_month_length (res_month_length),
        .o_date_valid   (res_date_valid),
        .o_out_of_range (res_out_of_range)
    );

    cddc_checker #(
        .YEAR_BITS(YEAR_W)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .i_in_stall     (req_stall),
        .i_func         (req_func),
        .i_year_in      (req_year),
        .i_month_in     (req_month),
        .i_day_in       (req_day),
        .i_day_count_in (req_count),
        .i_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .i_day_count_out(res_count),
        .i_year_out     (res_year),
        .i_month_out    (res_month),
        .i_day_out      (res_day),
        .i_leap_year    (res_leap),
        .i_month_length (res_month_length),
        .i_date_valid   (res_date_valid),
        .i_out_of_range (res_out_of_range),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        res_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    end

    task automatic send_request(
        input logic                            func,
        input logic signed [YEAR_W-1:0]        year,
        input logic [3:0]                      month,
        input logic [4:0]                      day,
        input logic signed [COUNT_W-1:0]       count
    );
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= func;
        req_year  <= year;
        req_month <= month;
        req_day   <= day;
        req_count <= count;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic send_date(input int year, input int month, input int day);
        send_request(cddc_tb_pkg::FUNC_DATE_TO_DAYS, YEAR_W'(year), 4'(month), 5'(day),
                     COUNT_W'($urandom));
    endtask

    task automatic send_count(input int count);
        send_request(cddc_tb_pkg::FUNC_DAYS_TO_DATE, YEAR_W'($urandom), 4'($urandom),
                     5'($urandom), COUNT_W'(count));
    endtask

    task automatic send_random_request();
        int year;
        int month;
        int day;
        int count;
        if ($urandom_range(1) == 0) begin
            case ($urandom_range(3))
                0: year = int'($urandom_range(65535)) - 32768;
                1: year = int'($urandom_range(800)) + 1600;
                2: year = int'($urandom_range(4000)) - 2000;
                default: year = $urandom_range(1) ? 32767 - int'($urandom_range(2))
                                                  : -32768 + int'($urandom_range(2));
            endcase
            month = ($urandom_range(9) < 8) ? $urandom_range(12, 1) : $urandom_range(15);
            day   = ($urandom_range(9) < 8) ? $urandom_range(31, 1) : $urandom_range(31);
            send_date(year, month, day);
        end else begin
            case ($urandom_range(4))
                0: count = int'($urandom_range(33554431)) - 16777216;
                1: count = int'($urandom_range(1600000)) - 800000;
                2: count = TOP_YEAR_LAST_DAY + int'($urandom_range(2000)) - 1000;
                3: count = BOTTOM_YEAR_FIRST_DAY + int'($urandom_range(2000)) - 1000;
                default: count = (int'($urandom_range(160)) - 80) * cddc_pkg::ERA_DAYS
                                 - cddc_pkg::EPOCH_SHIFT + int'($urandom_range(6)) - 3;
            endcase
            send_count(count);
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_func  <= cddc_tb_pkg::FUNC_DATE_TO_DAYS;
        req_year  <= '0;
        req_month <= '0;
        req_day   <= '0;
        req_count <= '0;
        no_idle   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_date(1970, 1, 1);
        send_date(2000, 2, 29);
        send_date(1900, 2, 29);
        send_date(0, 2, 29);
        send_date(0, 3, 1);
        send_date(-1, 12, 31);
        send_date(-32768, 1, 1);
        send_date(32767, 12, 31);
        send_date(-32768, 0, 0);
        send_date(32767, 15, 31);
        send_date(2023, 13, 5);
        send_date(2023, 4, 31);
        send_date(-400, 3, 0);
        send_count(0);
        send_count(-1);
        send_count(10957);
        send_count(16777215);
        send_count(-16777216);
        send_count(-cddc_pkg::EPOCH_SHIFT);
        send_count(-cddc_pkg::EPOCH_SHIFT - 1);
        send_count(TOP_YEAR_LAST_DAY);
        send_count(TOP_YEAR_LAST_DAY + 1);
        send_count(BOTTOM_YEAR_FIRST_DAY);
        send_count(BOTTOM_YEAR_FIRST_DAY - 1);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            no_idle <= (n >= 150 && n < 230);
            send_random_request();
        end
        req_valid <= 1'b0;
        no_idle   <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (cddc_pkg::PIPE_DEPTH + 4) @(posedge clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
